// File: rtl/mf3_pkg.sv
// Shared constants and types for the 3x3 median filter.
// No dependencies; imported by every module of the block.
package mf3_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;

    localparam int PIX_W        = 8;
    localparam int POS_W        = 10;
    localparam int CFG_W        = 11;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    localparam int WIN_N        = 9;
    localparam int WIN_SIDE     = 3;

    localparam int RES_W        = 2 * POS_W + PIX_W;
    localparam int S_DATA_W     = ((PIX_W + 7) / 8) * 8;
    localparam int M_DATA_W     = ((RES_W + 7) / 8) * 8;

    localparam int ADDR_W       = 1;
    localparam logic [ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    typedef pix_t [WIN_N-1:0] win_t;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } pos_t;

    typedef struct packed {
        logic valid;
        pos_t pos;
    } tag_t;

endpackage

// File: rtl/mf3_window.sv
// Position counters, the two line-store memories and the 3x3 window registers.
// Depends on mf3_pkg. Emits one registered window per interior pixel.
module mf3_window (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [mf3_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [mf3_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                         en,
    input  logic                         in_valid,
    input  mf3_pkg::pix_t                in_pix,
    output mf3_pkg::tag_t                out_tag,
    output mf3_pkg::win_t                out_win
);
    import mf3_pkg::*;

    function automatic logic [COL_W-1:0] last_col(input logic [CFG_W-1:0] v);
        int n;
        n = int'(v);
        if (n < WIN_SIDE) begin
            return COL_W'(WIN_SIDE - 1);
        end else if (n > MAX_WIDTH) begin
            return COL_W'(MAX_WIDTH - 1);
        end
        return COL_W'(n - 1);
    endfunction

    function automatic logic [ROW_W-1:0] last_row(input logic [CFG_W-1:0] v);
        int n;
        n = int'(v);
        if (n < WIN_SIDE) begin
            return ROW_W'(WIN_SIDE - 1);
        end else if (n > MAX_HEIGHT) begin
            return ROW_W'(MAX_HEIGHT - 1);
        end
        return ROW_W'(n - 1);
    endfunction

    logic [COL_W-1:0] col_reg, col_next, wlast_reg, rd_addr;
    logic [ROW_W-1:0] row_reg, row_next, hlast_reg;
    logic             accept;
    logic             interior;

    pix_t upper_mem  [MAX_WIDTH];
    pix_t middle_mem [MAX_WIDTH];
    pix_t top_rd_reg, mid_rd_reg;

    // columns c-2 and c-1: top, middle, bottom
    pix_t win_regs_reg [6];

    tag_t tag_reg;
    win_t win_reg;

    assign accept   = in_valid && en;
    assign interior = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_reg >= wlast_reg) begin
                col_next = '0;
                row_next = (row_reg >= hlast_reg) ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // prefetch the column of the next item; next column never equals the one written
    assign rd_addr = aresetn ? col_next : '0;

    always_ff @(posedge aclk) begin
        top_rd_reg <= upper_mem[rd_addr];
        mid_rd_reg <= middle_mem[rd_addr];
        if (accept) begin
            upper_mem[col_reg]  <= mid_rd_reg;
            middle_mem[col_reg] <= in_pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            wlast_reg     <= last_col(CFG_W'(RESET_WIDTH));
            hlast_reg     <= last_row(CFG_W'(RESET_HEIGHT));
            tag_reg.valid <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                win_regs_reg[i] <= '0;
            end
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_IMAGE_WIDTH:  wlast_reg <= last_col(cfg_wdata);
                    REG_IMAGE_HEIGHT: hlast_reg <= last_row(cfg_wdata);
                    default: ;
                endcase
            end
            if (accept) begin
                win_regs_reg[0] <= win_regs_reg[3];
                win_regs_reg[1] <= win_regs_reg[4];
                win_regs_reg[2] <= win_regs_reg[5];
                win_regs_reg[3] <= top_rd_reg;
                win_regs_reg[4] <= mid_rd_reg;
                win_regs_reg[5] <= in_pix;
            end
            if (en) begin
                tag_reg.valid <= accept && interior;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg.pos.row <= POS_W'(row_reg - ROW_W'(1));
            tag_reg.pos.col <= POS_W'(col_reg - COL_W'(1));
            win_reg[0]      <= win_regs_reg[0];
            win_reg[1]      <= win_regs_reg[3];
            win_reg[2]      <= top_rd_reg;
            win_reg[3]      <= win_regs_reg[1];
            win_reg[4]      <= win_regs_reg[4];
            win_reg[5]      <= mid_rd_reg;
            win_reg[6]      <= win_regs_reg[2];
            win_reg[7]      <= win_regs_reg[5];
            win_reg[8]      <= in_pix;
        end
    end

    assign out_tag = tag_reg;
    assign out_win = win_reg;

endmodule

// File: rtl/mf3_median.sv
// Two-stage median-of-nine network: sort each row triple, then combine.
// Depends on mf3_pkg. Final three-way median is left to the output register.
module mf3_median (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  mf3_pkg::tag_t in_tag,
    input  mf3_pkg::win_t in_win,
    output mf3_pkg::tag_t out_tag,
    output mf3_pkg::pix_t out_med
);
    import mf3_pkg::*;

    function automatic pix_t min2(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
        return min2(min2(a, b), c);
    endfunction

    function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
        return max2(max2(a, b), c);
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    pix_t lo_a_reg [WIN_SIDE];
    pix_t md_a_reg [WIN_SIDE];
    pix_t hi_a_reg [WIN_SIDE];
    tag_t tag_a_reg;

    pix_t lo_b_reg, md_b_reg, hi_b_reg;
    tag_t tag_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_a_reg.valid <= 1'b0;
            tag_b_reg.valid <= 1'b0;
        end else if (en) begin
            tag_a_reg.valid <= in_tag.valid;
            tag_b_reg.valid <= tag_a_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int g = 0; g < WIN_SIDE; g++) begin
                lo_a_reg[g] <= min3(in_win[3*g], in_win[3*g+1], in_win[3*g+2]);
                md_a_reg[g] <= med3(in_win[3*g], in_win[3*g+1], in_win[3*g+2]);
                hi_a_reg[g] <= max3(in_win[3*g], in_win[3*g+1], in_win[3*g+2]);
            end
            tag_a_reg.pos <= in_tag.pos;
            lo_b_reg      <= max3(lo_a_reg[0], lo_a_reg[1], lo_a_reg[2]);
            md_b_reg      <= med3(md_a_reg[0], md_a_reg[1], md_a_reg[2]);
            hi_b_reg      <= min3(hi_a_reg[0], hi_a_reg[1], hi_a_reg[2]);
            tag_b_reg.pos <= tag_a_reg.pos;
        end
    end

    assign out_tag = tag_b_reg;
    assign out_med = med3(lo_b_reg, md_b_reg, hi_b_reg);

endmodule

// File: rtl/median_3x3_filter.sv
// Top level of the 3x3 median filter: window builder, median network, output skid.
// Depends on mf3_pkg, mf3_window and mf3_median.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: pixel_value
//  m_      | out | m_tvalid/m_tready  | m_tdata: center_row, center_col, median
//  cfg_    | in  | cfg_wr_en          | cfg_addr, cfg_wdata (no read-back)
//
// One item per cycle while m_ is not stalled. A result reaches m_ through the window
// register (loaded at the accepting edge), then row sort, combine and the output register.
// Synchronous active-low reset; line stores are not cleared.
// A stall on m_ parks one result in the skid register, then holds s_tready
// low until that result drains.
module median_3x3_filter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [mf3_pkg::ADDR_W-1:0]    cfg_addr,
    input  logic [mf3_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mf3_pkg::S_DATA_W-1:0]  s_tdata,   // [7:0] pixel_value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mf3_pkg::M_DATA_W-1:0]  m_tdata    // [9:0] center_row,
                                                     // [19:10] center_col,
                                                     // [27:20] median_value
);
    import mf3_pkg::*;

    logic             en;
    tag_t             w_tag, p_tag;
    win_t             w_win;
    pix_t             p_med;
    logic [RES_W-1:0] p_data;

    logic             m_valid_reg;
    logic [RES_W-1:0] m_data_reg;
    logic             skid_valid_reg;
    logic [RES_W-1:0] skid_data_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    mf3_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_pix    (s_tdata[PIX_W-1:0]),
        .out_tag   (w_tag),
        .out_win   (w_win)
    );

    mf3_median u_median (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_tag  (w_tag),
        .in_win  (w_win),
        .out_tag (p_tag),
        .out_med (p_med)
    );

    assign p_data = {p_med, p_tag.pos.col, p_tag.pos.row};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !m_valid_reg) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg    <= p_tag.valid;
            end
        end else if (en && p_tag.valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !m_valid_reg) begin
            m_data_reg <= skid_valid_reg ? skid_data_reg : p_data;
        end else if (en && p_tag.valid) begin
            skid_data_reg <= p_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(m_data_reg);

endmodule

// File: rtl/mf3_checker.sv
// Port-level checks for the 3x3 median filter, bound to the top level.
// Depends on mf3_pkg and median_3x3_filter.
module mf3_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [mf3_pkg::M_DATA_W-1:0]  m_tdata
);
    import mf3_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[POS_W-1:0] != '0 && m_tdata[2*POS_W-1:POS_W] != '0)
        else $error("result on a border position");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without an output stall");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not idle after reset");

endmodule

bind median_3x3_filter mf3_checker u_mf3_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: dv/testbench.sv
// Self-checking testbench for median_3x3_filter: streams pixel frames through s_,
// predicts every filtered item with a behavioral window model and checks m_ in order.
// Depends on mf3_pkg and the median_3x3_filter RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mf3_pkg::*;

    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 450;

    typedef enum int {PAT_RANDOM, PAT_FLAT, PAT_BINARY, PAT_NARROW} pix_pattern_e;

    // row in the lowest bits, as on m_tdata
    typedef struct packed {
        logic [PIX_W-1:0] median;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
    } median_item_t;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [ADDR_W-1:0]   cfg_addr  = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // window model state
    bit [CFG_W-1:0] width_reg  = CFG_W'(RESET_WIDTH);
    bit [CFG_W-1:0] height_reg = CFG_W'(RESET_HEIGHT);
    bit [PIX_W-1:0] upper_line  [MAX_WIDTH];
    bit [PIX_W-1:0] middle_line [MAX_WIDTH];
    bit [PIX_W-1:0] win_cols [6];
    int unsigned    row_pos;
    int unsigned    col_pos;
    median_item_t   pending_medians [$];

    int err_count;
    int pixels_sent;
    int medians_seen;
    int reg_writes;
    int quiet_cycles;
    bit burst_mode;
    bit hold_req;

    median_3x3_filter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned eff_dim(input bit [CFG_W-1:0] v, input int unsigned limit);
        if (v < 3) return 3;
        if (v > limit) return limit;
        return 32'(v);
    endfunction

    function automatic bit [PIX_W-1:0] median_of_window(input bit [PIX_W-1:0] px [WIN_N]);
        bit [PIX_W-1:0] srt [WIN_N];
        bit [PIX_W-1:0] tmp;
        srt = px;
        for (int i = 1; i < WIN_N; i++) begin
            for (int j = i; j > 0 && srt[j] < srt[j-1]; j--) begin
                tmp      = srt[j];
                srt[j]   = srt[j-1];
                srt[j-1] = tmp;
            end
        end
        return srt[WIN_N/2];
    endfunction

    function automatic void filter_pixel(input bit [PIX_W-1:0] pix);
        int unsigned    w_eff;
        int unsigned    h_eff;
        bit [PIX_W-1:0] top;
        bit [PIX_W-1:0] mid;
        bit [PIX_W-1:0] nb [WIN_N];
        median_item_t   res;
        w_eff = eff_dim(width_reg, MAX_WIDTH);
        h_eff = eff_dim(height_reg, MAX_HEIGHT);
        top = '0;
        mid = '0;
        if (col_pos < MAX_WIDTH) begin
            top = upper_line[col_pos];
            mid = middle_line[col_pos];
        end
        if (row_pos >= 2 && col_pos >= 2) begin
            nb = '{win_cols[0], win_cols[3], top,
                   win_cols[1], win_cols[4], mid,
                   win_cols[2], win_cols[5], pix};
            res.row    = POS_W'(row_pos - 1);
            res.col    = POS_W'(col_pos - 1);
            res.median = median_of_window(nb);
            pending_medians.push_back(res);
        end
        win_cols = '{win_cols[3], win_cols[4], win_cols[5], top, mid, pix};
        if (col_pos < MAX_WIDTH) begin
            upper_line[col_pos]  = mid;
            middle_line[col_pos] = pix;
        end
        if (col_pos >= w_eff - 1) begin
            col_pos = 0;
            row_pos = (row_pos >= h_eff - 1) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endfunction

    function automatic bit [PIX_W-1:0] draw_pixel(input pix_pattern_e pat,
                                                  input bit [PIX_W-1:0] base);
        case (pat)
            PAT_FLAT:   return base;
            PAT_BINARY: return $urandom_range(0, 1) ? '1 : '0;
            PAT_NARROW: return base + PIX_W'($urandom_range(0, 3));
            default:    return PIX_W'($urandom);
        endcase
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    task automatic push_pixel(input bit [PIX_W-1:0] pix);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(pix);
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        filter_pixel(pix);
        pixels_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_medians.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] idx, input int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_W'(val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == REG_IMAGE_WIDTH) begin
            width_reg = CFG_W'(val);
        end else begin
            height_reg = CFG_W'(val);
        end
        reg_writes++;
    endtask

    // only called at a frame start, so a wider frame never reads stale line data
    task automatic set_frame(input int unsigned w, input int unsigned h);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    task automatic send_until_wrap(input pix_pattern_e pat, input bit [PIX_W-1:0] base);
        do push_pixel(draw_pixel(pat, base)); while (!(row_pos == 0 && col_pos == 0));
    endtask

    task automatic test_min_frame();
        bit [PIX_W-1:0] px [9] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd170,
                                   8'd0, 8'd255, 8'd85, 8'd254};
        set_frame(0, 2);
        foreach (px[i]) push_pixel(px[i]);
    endtask

    task automatic test_midframe_resize();
        set_frame(5, 5);
        repeat (13) push_pixel(draw_pixel(PAT_RANDOM, '0));
        // column already past the new last column: wraps on the next pixel
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 3);
        push_pixel(draw_pixel(PAT_RANDOM, '0));
        // row already past the new last row: wraps at the end of this row
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 0);
        send_until_wrap(PAT_RANDOM, '0);
    endtask

    task automatic test_backpressure();
        set_frame(40, 4);
        hold_req   = 1'b1;
        burst_mode = 1'b1;
        send_until_wrap(PAT_RANDOM, '0);
        burst_mode = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_frames();
        int           start;
        int unsigned  w;
        int unsigned  h;
        int           n;
        int           cut_at;
        pix_pattern_e pat;
        bit [PIX_W-1:0] base;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 2);
                1:       w = $urandom_range(13, 40);
                default: w = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 9))
                0:       h = $urandom_range(0, 2);
                1:       h = $urandom_range(9, 16);
                default: h = $urandom_range(3, 8);
            endcase
            set_frame(w, h);
            pat  = $urandom_range(0, 1) ? PAT_RANDOM : pix_pattern_e'($urandom_range(0, 3));
            base = PIX_W'($urandom);
            burst_mode = ($urandom_range(0, 3) == 0);
            cut_at = ($urandom_range(0, 3) == 0)
                   ? $urandom_range(1, eff_dim(CFG_W'(w), MAX_WIDTH)
                                       * eff_dim(CFG_W'(h), MAX_HEIGHT)) : 0;
            n = 0;
            do begin
                push_pixel(draw_pixel(pat, base));
                n++;
                if (n == cut_at) begin
                    wait_idle();
                    // mid-frame: width never grows, height may go either way
                    if ($urandom_range(0, 1)) begin
                        write_reg(REG_IMAGE_WIDTH,
                                  $urandom_range(0, eff_dim(width_reg, MAX_WIDTH)));
                    end else begin
                        write_reg(REG_IMAGE_HEIGHT, $urandom_range(0, 12));
                    end
                end
            end while (!(row_pos == 0 && col_pos == 0));
        end
        burst_mode = 1'b0;
    endtask

    // result side: random ready gaps, plus one long hold when requested
    initial begin : result_sink
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = burst_mode ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge aclk) begin
        median_item_t got;
        median_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            medians_seen++;
            got = median_item_t'(m_tdata[RES_W-1:0]);
            if (pending_medians.size() == 0) begin
                report("unexpected item, median", got.median, -1);
            end else begin
                want = pending_medians.pop_front();
                if (got.row !== want.row) report("center_row", got.row, want.row);
                if (got.col !== want.col) report("center_col", got.col, want.col);
                if (got.median !== want.median) report("median_value", got.median, want.median);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d items outstanding",
                         STALL_LIMIT, pending_medians.size());
                $display("median_3x3_filter regression: fail");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_min_frame();
        test_midframe_resize();
        test_backpressure();
        test_random_frames();
        wait_idle();
        $display("sent %0d pixels, checked %0d medians, %0d register writes, %0d mismatches",
                 pixels_sent, medians_seen, reg_writes, err_count);
        $display("frames from clamped 3x3 up to 40 wide and 16 tall, mid-frame resizes, "
                 , "long output stall");
        if (err_count == 0) begin
            $display("median_3x3_filter regression: pass");
        end else begin
            $display("median_3x3_filter regression: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/mf3_pkg.sv
rtl/mf3_window.sv
rtl/mf3_median.sv
rtl/median_3x3_filter.sv
rtl/mf3_checker.sv
dv/testbench.sv
